### rtl/trend_season_neg_log_posterior_defines.svh
// ----------------------------------------------------------------------------
// Trend/season objective assertion macros
// Shared property wrappers for the concurrent checks of the top level.
// ----------------------------------------------------------------------------
`ifndef TREND_SEASON_NEG_LOG_POSTERIOR_DEFINES_SVH
`define TREND_SEASON_NEG_LOG_POSTERIOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TSNLP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TSNLP_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/tsnlp_pkg.sv
// ----------------------------------------------------------------------------
// Trend/season objective package
// Function codes, register indexes and CORDIC constants.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tsnlp_pkg;

	typedef enum logic [1:0] {
		FN_PARAM  = 2'd0,
		FN_CP     = 2'd1,
		FN_SAMPLE = 2'd2
	} func_t;

	typedef enum logic [2:0] {
		REG_INV_OBS    = 3'd0,
		REG_INV_SLOPE  = 3'd1,
		REG_INV_OFFSET = 3'd2,
		REG_INV_SEASON = 3'd3,
		REG_INV_LAPL   = 3'd4,
		REG_TURN_STEP  = 3'd5
	} reg_idx_t;

	localparam int          CORDIC_STEPS = 24;
	localparam logic [33:0] CORDIC_GAIN  = 34'h026DD3B6A;
	localparam int          NUM_TERMS    = 5;
	localparam logic [62:0] CAP63        = {63{1'b1}};

	// Arctangent of 2^-i, in turns scaled by 2^32.
	function automatic logic [29:0] atan_turn(input logic [4:0] i);
		logic [29:0] r;
		unique case (i)
			5'd0:  r = 30'h20000000;
			5'd1:  r = 30'h12E4051E;
			5'd2:  r = 30'h09FB385B;
			5'd3:  r = 30'h051111D4;
			5'd4:  r = 30'h028B0D43;
			5'd5:  r = 30'h0145D7E1;
			5'd6:  r = 30'h00A2F61E;
			5'd7:  r = 30'h00517C55;
			5'd8:  r = 30'h0028BE53;
			5'd9:  r = 30'h00145F2F;
			5'd10: r = 30'h000A2F98;
			5'd11: r = 30'h000517CC;
			5'd12: r = 30'h00028BE6;
			5'd13: r = 30'h000145F3;
			5'd14: r = 30'h0000A2F9;
			5'd15: r = 30'h0000517C;
			5'd16: r = 30'h000028BE;
			5'd17: r = 30'h0000145F;
			5'd18: r = 30'h00000A2F;
			5'd19: r = 30'h00000517;
			5'd20: r = 30'h0000028B;
			5'd21: r = 30'h00000145;
			5'd22: r = 30'h000000A2;
			5'd23: r = 30'h00000051;
			default: r = 30'h0;
		endcase
		return r;
	endfunction

endpackage

### rtl/tsnlp_ram.sv
// ----------------------------------------------------------------------------
// Trend/season objective RAM
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tsnlp_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                                         clk,
	input  logic                                         we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                             wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                             rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### rtl/trend_season_neg_log_posterior.sv
// ----------------------------------------------------------------------------
// Trend/season negative log posterior
// Loads, one sample at a time, run through one shared 33x33 multiplier.
// ----------------------------------------------------------------------------
// Parameter and change-point loads never raise busy. A sample holds busy while it
// runs through the serial CORDIC and the single shared multiplier. A last sample
// then also forms the prior terms and ends with a one-cycle done beat.
// Reset clears the sequencer, error accumulator, flag and config registers;
// the stores are undefined until written. Results cannot be stalled.
`timescale 1ns / 1ps
`include "trend_season_neg_log_posterior_defines.svh"

module trend_season_neg_log_posterior
	import tsnlp_pkg::*;
#(
	parameter int NUM_CHANGEPOINTS = 25,
	parameter int NUM_HARMONICS    = 10,
	parameter int DATA_WIDTH       = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         func,
	input  logic [5:0]         slot,
	input  logic signed [31:0] value,
	input  logic signed [31:0] sample_time,
	input  logic               last,
	output logic               done,
	output logic [62:0]        objective,
	output logic               saturated,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [4:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	localparam int NP    = 2 + NUM_CHANGEPOINTS + 2 * NUM_HARMONICS;
	localparam int PAW   = $clog2(NP);
	localparam int CAW   = (NUM_CHANGEPOINTS > 1) ? $clog2(NUM_CHANGEPOINTS) : 1;
	localparam int IW    = $clog2(NP + 1);
	localparam int HW    = $clog2(NUM_HARMONICS + 1);
	localparam int SXS   = 32 - DATA_WIDTH;
	localparam int DSW   = 33 + $clog2(NUM_CHANGEPOINTS + 1);
	localparam int DBASE = 2;
	localparam int CBASE = 2 + NUM_CHANGEPOINTS;
	localparam int SBASE = 2 + NUM_CHANGEPOINTS + NUM_HARMONICS;
	localparam logic signed [63:0] ERR_LIM = 64'sd4294967296;

	typedef enum logic [4:0] {
		ST_IDLE, ST_T_RD, ST_T_K, ST_T_M, ST_C_RD, ST_C_MUL, ST_C_ACC,
		ST_B_MUL, ST_B_ST, ST_R_INIT, ST_R_IT, ST_R_FIN, ST_H_C, ST_H_S, ST_H_SA,
		ST_E_ERR, ST_E_MUL, ST_E_ACC, ST_L_RD, ST_L_MUL, ST_L_ACC,
		ST_M_HI, ST_M_LO, ST_M_SUM, ST_M_ADD
	} state_t;

	state_t state_q;

	// Configuration registers
	logic [31:0] inv_obs_q, inv_slope_q, inv_offset_q, inv_season_q, inv_lapl_q, step_q;
	logic        cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_obs_q    <= 32'd65536;
			inv_slope_q  <= 32'd65536;
			inv_offset_q <= 32'd65536;
			inv_season_q <= 32'd65536;
			inv_lapl_q   <= 32'd65536;
			step_q       <= 32'd11758910;
		end else if (cfg_wr) begin
			unique case (paddr[4:2])
				REG_INV_OBS:    inv_obs_q    <= pwdata;
				REG_INV_SLOPE:  inv_slope_q  <= pwdata;
				REG_INV_OFFSET: inv_offset_q <= pwdata;
				REG_INV_SEASON: inv_season_q <= pwdata;
				REG_INV_LAPL:   inv_lapl_q   <= pwdata;
				REG_TURN_STEP:  step_q       <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[4:2])
			REG_INV_OBS:    prdata = inv_obs_q;
			REG_INV_SLOPE:  prdata = inv_slope_q;
			REG_INV_OFFSET: prdata = inv_offset_q;
			REG_INV_SEASON: prdata = inv_season_q;
			REG_INV_LAPL:   prdata = inv_lapl_q;
			REG_TURN_STEP:  prdata = step_q;
			default:        prdata = 32'd0;
		endcase
	end

	// Input beat and stores
	logic               accept;
	logic signed [31:0] value_sx, time_sx;
	logic               prm_we, cp_we;
	logic [PAW-1:0]     prm_raddr;
	logic [CAW-1:0]     cp_raddr;
	logic [DATA_WIDTH-1:0] prm_rd, cp_rd;
	logic signed [32:0] prm_sx, cp_sx;

	assign busy     = (state_q != ST_IDLE);
	assign accept   = start & ~busy;
	assign value_sx = (value <<< SXS) >>> SXS;
	assign time_sx  = (sample_time <<< SXS) >>> SXS;
	assign prm_we   = accept && (func == FN_PARAM) && (int'(slot) < NP);
	assign cp_we    = accept && (func == FN_CP) && (int'(slot) < NUM_CHANGEPOINTS);
	assign prm_sx   = {{(33 - DATA_WIDTH){prm_rd[DATA_WIDTH-1]}}, prm_rd};
	assign cp_sx    = {{(33 - DATA_WIDTH){cp_rd[DATA_WIDTH-1]}}, cp_rd};

	tsnlp_ram #(.WIDTH(DATA_WIDTH), .DEPTH(NP)) u_prm_ram (
		.clk   (clk),
		.we    (prm_we),
		.waddr (PAW'(slot)),
		.wdata (value_sx[DATA_WIDTH-1:0]),
		.raddr (prm_raddr),
		.rdata (prm_rd)
	);

	tsnlp_ram #(.WIDTH(DATA_WIDTH), .DEPTH(NUM_CHANGEPOINTS)) u_cp_ram (
		.clk   (clk),
		.we    (cp_we),
		.waddr (CAW'(slot)),
		.wdata (value_sx[DATA_WIDTH-1:0]),
		.raddr (cp_raddr),
		.rdata (cp_rd)
	);

	// Sequencer counters and datapath registers
	logic [IW-1:0]  idx_q;
	logic [HW-1:0]  h_q;
	logic [4:0]     it_q;
	logic [2:0]     j_q;
	logic [63:0]    acc_q;
	logic           flag_q;

	logic signed [31:0] tim_q, obs_q;
	logic               last_q, act_q, big_q;
	logic signed [63:0] g_q, sacc_q, err_q;
	logic [47:0]        base_q, ang_q;
	logic signed [33:0] cx_q, cy_q;
	logic signed [32:0] cz_q;
	logic [1:0]         quad_q;
	logic signed [20:0] cv_q, sv_q;
	logic [63:0]        k2_q, m2_q, bsum_q, hi_q;
	logic [DSW-1:0]     dsum_q;
	logic [62:0]        tot_q, term_q;
	logic signed [65:0] prod_q;

	always_comb begin
		unique case (state_q)
			ST_T_K:  prm_raddr = PAW'(1);
			ST_C_RD: prm_raddr = PAW'(int'(idx_q) + DBASE);
			ST_R_FIN: prm_raddr = PAW'(int'(h_q) + CBASE);
			ST_H_C:  prm_raddr = PAW'(int'(h_q) + SBASE);
			ST_L_RD: prm_raddr = PAW'(idx_q);
			default: prm_raddr = PAW'(0);
		endcase
	end
	assign cp_raddr = idx_q[CAW-1:0];

	// Operand for the split prior multiply
	logic [63:0] a_sel;
	logic [31:0] b_sel;
	always_comb begin
		unique case (j_q)
			3'd0:    begin a_sel = acc_q;                b_sel = inv_obs_q;    end
			3'd1:    begin a_sel = k2_q;                 b_sel = inv_slope_q;  end
			3'd2:    begin a_sel = m2_q;                 b_sel = inv_offset_q; end
			3'd3:    begin a_sel = bsum_q;               b_sel = inv_season_q; end
			default: begin a_sel = 64'({dsum_q, 16'd0}); b_sel = inv_lapl_q;   end
		endcase
	end

	logic signed [63:0] mag;
	assign mag = err_q[63] ? -err_q : err_q;

	// The shared multiplier: operand select, then a product register.
	logic signed [32:0] mul_a, mul_b;
	always_comb begin
		mul_a = prm_sx;
		mul_b = prm_sx;
		unique case (state_q)
			ST_T_K:   mul_b = 33'(tim_q);
			ST_C_MUL: mul_b = 33'(tim_q) - cp_sx;
			ST_B_MUL: begin mul_a = 33'(tim_q); mul_b = {1'b0, step_q}; end
			ST_H_C:   mul_b = 33'(cv_q);
			ST_H_S:   mul_b = 33'(sv_q);
			ST_E_MUL: begin mul_a = {1'b0, mag[31:0]}; mul_b = {1'b0, mag[31:0]}; end
			ST_M_HI:  begin mul_a = {1'b0, a_sel[63:32]}; mul_b = {1'b0, b_sel}; end
			ST_M_LO:  begin mul_a = {1'b0, a_sel[31:0]};  mul_b = {1'b0, b_sel}; end
			default: ;
		endcase
	end

	// Saturating sums used by the sequencer.
	logic [64:0] acc_sum, bsum_sum;
	logic [63:0] r_mul;
	logic        hi_cap;
	logic [63:0] tot_sum;
	assign acc_sum  = {1'b0, acc_q} + {1'b0, prod_q[63:0]};
	assign bsum_sum = {1'b0, bsum_q} + {1'b0, prod_q[63:0]};
	assign hi_cap   = |hi_q[63:47];
	assign r_mul    = {hi_q[47:0], 16'd0} + (prod_q[63:0] >> 16);
	assign tot_sum  = {1'b0, tot_q} + {1'b0, term_q};

	logic signed [33:0] dx, dy;
	logic signed [20:0] xs, ys;
	assign dx = cy_q >>> it_q;
	assign dy = cx_q >>> it_q;
	assign xs = 21'(cx_q >>> 14);
	assign ys = 21'(cy_q >>> 14);

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					tim_q  <= time_sx;
					obs_q  <= value_sx;
					last_q <= last;
				end
			end
			ST_T_M:   g_q <= 64'(prod_q >>> 16) + 64'(prm_sx);
			ST_C_MUL: act_q <= (33'(tim_q) > cp_sx);
			ST_C_ACC: begin
				if (act_q) begin
					g_q <= g_q + 64'(prod_q >>> 16);
				end
			end
			ST_B_ST: begin
				base_q <= prod_q[47:0];
				ang_q  <= prod_q[47:0];
				sacc_q <= 64'sd0;
			end
			ST_R_INIT: begin
				cx_q   <= CORDIC_GAIN;
				cy_q   <= 34'sd0;
				cz_q   <= {3'b000, ang_q[45:16]};
				quad_q <= ang_q[47:46];
			end
			ST_R_IT: begin
				if (!cz_q[32]) begin
					cx_q <= cx_q - dx;
					cy_q <= cy_q + dy;
					cz_q <= cz_q - 33'(atan_turn(it_q));
				end else begin
					cx_q <= cx_q + dx;
					cy_q <= cy_q - dy;
					cz_q <= cz_q + 33'(atan_turn(it_q));
				end
			end
			ST_R_FIN: begin
				unique case (quad_q)
					2'd0: begin cv_q <= xs;  sv_q <= ys;  end
					2'd1: begin cv_q <= -ys; sv_q <= xs;  end
					2'd2: begin cv_q <= -xs; sv_q <= -ys; end
					default: begin cv_q <= ys; sv_q <= -xs; end
				endcase
			end
			ST_H_S: sacc_q <= sacc_q + prod_q[63:0];
			ST_H_SA: begin
				sacc_q <= sacc_q + prod_q[63:0];
				ang_q  <= ang_q + base_q;
			end
			ST_E_ERR: err_q <= 64'(obs_q) - (g_q + (sacc_q >>> 16));
			ST_E_MUL: big_q <= (err_q >= ERR_LIM) || (err_q <= -ERR_LIM);
			ST_E_ACC: begin
				dsum_q <= '0;
				bsum_q <= 64'd0;
			end
			ST_L_MUL: begin
				if (int'(idx_q) >= DBASE && int'(idx_q) < CBASE) begin
					dsum_q <= dsum_q + DSW'(prm_sx[32] ? -prm_sx : prm_sx);
				end
			end
			ST_L_ACC: begin
				if (int'(idx_q) == 0) begin
					k2_q <= prod_q[63:0];
				end else if (int'(idx_q) == 1) begin
					m2_q <= prod_q[63:0];
				end else if (int'(idx_q) >= CBASE) begin
					bsum_q <= bsum_sum[64] ? {64{1'b1}} : bsum_sum[63:0];
				end
				tot_q <= 63'd0;
			end
			ST_M_LO:  hi_q <= prod_q[63:0];
			ST_M_SUM: term_q <= (hi_cap || r_mul[63]) ? CAP63 : r_mul[62:0];
			ST_M_ADD: tot_q <= tot_sum[63] ? CAP63 : tot_sum[62:0];
			default: ;
		endcase
	end

	// Sequencer state and registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			idx_q     <= '0;
			h_q       <= '0;
			it_q      <= 5'd0;
			j_q       <= 3'd0;
			acc_q     <= 64'd0;
			flag_q    <= 1'b0;
			done      <= 1'b0;
			objective <= 63'd0;
			saturated <= 1'b0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept && func == FN_SAMPLE) begin
						state_q <= ST_T_RD;
					end
				end
				ST_T_RD: state_q <= ST_T_K;
				ST_T_K:  state_q <= ST_T_M;
				ST_T_M: begin
					idx_q   <= '0;
					state_q <= ST_C_RD;
				end
				ST_C_RD:  state_q <= ST_C_MUL;
				ST_C_MUL: state_q <= ST_C_ACC;
				ST_C_ACC: begin
					idx_q <= idx_q + 1'b1;
					if (int'(idx_q) == NUM_CHANGEPOINTS - 1) begin
						state_q <= ST_B_MUL;
					end else begin
						state_q <= ST_C_RD;
					end
				end
				ST_B_MUL: state_q <= ST_B_ST;
				ST_B_ST: begin
					h_q     <= '0;
					state_q <= ST_R_INIT;
				end
				ST_R_INIT: begin
					it_q    <= 5'd0;
					state_q <= ST_R_IT;
				end
				ST_R_IT: begin
					it_q <= it_q + 5'd1;
					if (it_q == 5'(CORDIC_STEPS - 1)) begin
						state_q <= ST_R_FIN;
					end
				end
				ST_R_FIN: state_q <= ST_H_C;
				ST_H_C:   state_q <= ST_H_S;
				ST_H_S:   state_q <= ST_H_SA;
				ST_H_SA: begin
					h_q <= h_q + 1'b1;
					if (int'(h_q) == NUM_HARMONICS - 1) begin
						state_q <= ST_E_ERR;
					end else begin
						state_q <= ST_R_INIT;
					end
				end
				ST_E_ERR: state_q <= ST_E_MUL;
				ST_E_MUL: state_q <= ST_E_ACC;
				ST_E_ACC: begin
					// A squared error that cannot fit, or a sum that overflows, pins the sum at full scale.
					if (big_q || acc_sum[64]) begin
						acc_q  <= {64{1'b1}};
						flag_q <= 1'b1;
					end else begin
						acc_q <= acc_sum[63:0];
					end
					idx_q <= '0;
					if (last_q) begin
						state_q <= ST_L_RD;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_L_RD:  state_q <= ST_L_MUL;
				ST_L_MUL: state_q <= ST_L_ACC;
				ST_L_ACC: begin
					if (int'(idx_q) >= CBASE && bsum_sum[64]) begin
						flag_q <= 1'b1;
					end
					idx_q <= idx_q + 1'b1;
					j_q   <= 3'd0;
					if (int'(idx_q) == NP - 1) begin
						state_q <= ST_M_HI;
					end else begin
						state_q <= ST_L_RD;
					end
				end
				ST_M_HI: state_q <= ST_M_LO;
				ST_M_LO: state_q <= ST_M_SUM;
				ST_M_SUM: begin
					if (hi_cap || r_mul[63]) begin
						flag_q <= 1'b1;
					end
					state_q <= ST_M_ADD;
				end
				ST_M_ADD: begin
					if (int'(j_q) == NUM_TERMS - 1) begin
						objective <= tot_sum[63] ? CAP63 : tot_sum[62:0];
						saturated <= flag_q | tot_sum[63];
						done      <= 1'b1;
						acc_q     <= 64'd0;
						flag_q    <= 1'b0;
						state_q   <= ST_IDLE;
					end else begin
						if (tot_sum[63]) begin
							flag_q <= 1'b1;
						end
						j_q     <= j_q + 3'd1;
						state_q <= ST_M_HI;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`TSNLP_ASSERT_IMP(a_done_idle, clk, arst_n, done, !busy, "result beat while busy")
	`TSNLP_ASSERT_NXT(a_sample_busy, clk, arst_n, start && !busy && (func == FN_SAMPLE), busy, "sample beat did not start the sequencer")
	`TSNLP_ASSERT_NXT(a_done_pulse, clk, arst_n, done, !done, "result strobe held longer than one beat")
	`TSNLP_ASSERT_IMP(a_cordic_cnt, clk, arst_n, state_q == ST_R_IT, it_q < 5'(CORDIC_STEPS), "CORDIC step count overran")

endmodule

### tb/sv/tsnlp_objective_checker.sv
// ----------------------------------------------------------------------------
// Trend/season objective checker
// Watches the command, result and register ports, predicts each objective
// beat in fixed point and compares it with the block's result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tsnlp_objective_checker
	import tsnlp_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  logic [1:0]         func,
	input  logic [5:0]         slot,
	input  logic signed [31:0] value,
	input  logic signed [31:0] sample_time,
	input  logic               last,
	input  logic               done,
	input  logic [62:0]        objective,
	input  logic               saturated,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic               pready,
	input  logic [4:0]         paddr,
	input  logic [31:0]        pwdata,
	output int                 fail_count,
	output int                 pending,
	output int                 samples_seen,
	output int                 objectives_seen
);

	localparam int NCP    = 25;
	localparam int NHARM  = 10;
	localparam int NPARAM = 2 + NCP + 2 * NHARM;
	localparam int BETA0  = 2 + NCP;
	localparam bit [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam bit [63:0] TOP63    = 64'h7FFF_FFFF_FFFF_FFFF;

	localparam longint ATAN_TBL [24] = '{
		64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
		64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
		64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2F9,
		64'h0000517C, 64'h000028BE, 64'h0000145F, 64'h00000A2F, 64'h00000517,
		64'h0000028B, 64'h00000145, 64'h000000A2, 64'h00000051
	};

	typedef struct packed {
		logic [62:0] obj;
		logic        sat;
	} objective_beat_t;

	objective_beat_t expected_objectives[$];

	bit [31:0] w_obs, w_slope, w_offset, w_season, w_laplace, turn_step;
	logic signed [31:0] params [NPARAM];
	logic signed [31:0] cps [NCP];
	bit [63:0] sq_err_sum;
	bit        sq_err_sat;

	function automatic bit [63:0] add_sat64(bit [63:0] a, bit [63:0] b, ref bit f);
		bit [63:0] r;
		r = a + b;
		if (r < a) begin
			f = 1'b1;
			return ALL_ONES;
		end
		return r;
	endfunction

	function automatic bit [63:0] add_sat63(bit [63:0] a, bit [63:0] b, ref bit f);
		bit [63:0] r;
		r = a + b;
		if (r > TOP63) begin
			f = 1'b1;
			return TOP63;
		end
		return r;
	endfunction

	// Product of a 64-bit value and a Q16.16 weight, capped at 2^63-1.
	function automatic bit [63:0] weigh(bit [63:0] a, bit [31:0] b, ref bit f);
		bit [63:0] hi, lo, r;
		hi = (a >> 32) * 64'(b);
		lo = (a & 64'hFFFF_FFFF) * 64'(b);
		if ((hi >> 47) != 0) begin
			f = 1'b1;
			return TOP63;
		end
		r = (hi << 16) + (lo >> 16);
		if (r > TOP63) begin
			f = 1'b1;
			return TOP63;
		end
		return r;
	endfunction

	function automatic void rotate(bit [31:0] ang, output longint c, output longint s);
		longint x, y, z, dx, dy;
		x = 64'h26DD3B6A;
		y = 0;
		z = longint'(ang[29:0]);
		for (int i = 0; i < 24; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx; y += dy; z -= ATAN_TBL[i];
			end else begin
				x += dx; y -= dy; z += ATAN_TBL[i];
			end
		end
		x = x >>> 14;
		y = y >>> 14;
		case (ang[31:30])
			2'd0: begin c = x;  s = y;  end
			2'd1: begin c = -y; s = x;  end
			2'd2: begin c = -x; s = -y; end
			default: begin c = y; s = -x; end
		endcase
	endfunction

	function automatic void add_sample(logic signed [31:0] y, logic signed [31:0] t);
		longint g, season, err, cv, sv;
		bit [63:0] tu, p, mag;
		g = ((longint'(params[0]) * longint'(t)) >>> 16) + longint'(params[1]);
		for (int i = 0; i < NCP; i++)
			if (t > cps[i])
				g += (longint'(params[2 + i]) * (longint'(t) - longint'(cps[i]))) >>> 16;
		tu = 64'(longint'(t));
		season = 0;
		for (int h = 1; h <= NHARM; h++) begin
			p = tu * 64'(turn_step) * 64'(h);
			rotate(p[47:16], cv, sv);
			season += longint'(params[BETA0 + h - 1]) * cv;
			season += longint'(params[BETA0 + NHARM + h - 1]) * sv;
		end
		err = longint'(y) - (g + (season >>> 16));
		if (err >= 64'sh1_0000_0000 || err <= -64'sh1_0000_0000) begin
			sq_err_sum = ALL_ONES;
			sq_err_sat = 1'b1;
			return;
		end
		mag = (err < 0) ? 64'(-err) : 64'(err);
		sq_err_sum = add_sat64(sq_err_sum, mag * mag, sq_err_sat);
	endfunction

	function automatic objective_beat_t close_series();
		objective_beat_t b;
		bit f;
		bit [63:0] k2, m2, beta_sq, delta_abs, tot;
		longint v;
		f = sq_err_sat;
		k2 = 64'(longint'(params[0]) * longint'(params[0]));
		m2 = 64'(longint'(params[1]) * longint'(params[1]));
		beta_sq = 0;
		for (int i = 0; i < 2 * NHARM; i++) begin
			v = longint'(params[BETA0 + i]);
			beta_sq = add_sat64(beta_sq, 64'(v * v), f);
		end
		delta_abs = 0;
		for (int i = 0; i < NCP; i++) begin
			v = longint'(params[2 + i]);
			delta_abs += (v < 0) ? 64'(-v) : 64'(v);
		end
		tot = weigh(sq_err_sum, w_obs, f);
		tot = add_sat63(tot, weigh(k2, w_slope, f), f);
		tot = add_sat63(tot, weigh(m2, w_offset, f), f);
		tot = add_sat63(tot, weigh(beta_sq, w_season, f), f);
		tot = add_sat63(tot, weigh(delta_abs << 16, w_laplace, f), f);
		b.obj = tot[62:0];
		b.sat = f;
		sq_err_sum = 0;
		sq_err_sat = 1'b0;
		return b;
	endfunction

	assign pending = expected_objectives.size();

	always @(posedge clk or negedge arst_n) begin
		objective_beat_t want;
		if (!arst_n) begin
			w_obs <= 32'd65536; w_slope <= 32'd65536; w_offset <= 32'd65536;
			w_season <= 32'd65536; w_laplace <= 32'd65536; turn_step <= 32'd11758910;
			sq_err_sum = 0;
			sq_err_sat = 1'b0;
			fail_count <= 0;
			samples_seen <= 0;
			objectives_seen <= 0;
		end else begin
			if (done) begin
				objectives_seen <= objectives_seen + 1;
				if (expected_objectives.size() == 0) begin
					$display("%0t: unexpected objective beat %h sat %b", $time, objective,
						saturated);
					fail_count <= fail_count + 1;
				end else begin
					want = expected_objectives.pop_front();
					if (objective !== want.obj || saturated !== want.sat) begin
						$display("%0t: objective mismatch: expected %h sat %b, got %h sat %b",
							$time, want.obj, want.sat, objective, saturated);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (start && !busy) begin
				case (func_t'(func))
					FN_PARAM: if (slot < NPARAM) params[slot] = value;
					FN_CP:    if (slot < NCP) cps[slot] = value;
					FN_SAMPLE: begin
						samples_seen <= samples_seen + 1;
						add_sample(value, sample_time);
						if (last)
							expected_objectives.push_back(close_series());
					end
					default: ;
				endcase
			end
			if (psel && penable && pwrite && pready) begin
				case (reg_idx_t'(paddr[4:2]))
					REG_INV_OBS:    w_obs <= pwdata;
					REG_INV_SLOPE:  w_slope <= pwdata;
					REG_INV_OFFSET: w_offset <= pwdata;
					REG_INV_SEASON: w_season <= pwdata;
					REG_INV_LAPL:   w_laplace <= pwdata;
					REG_TURN_STEP:  turn_step <= pwdata;
					default: ;
				endcase
			end
		end
	end

endmodule

### tb/sv/tb.sv
// ----------------------------------------------------------------------------
// Trend/season objective testbench
// Loads parameters and change points, streams sample series with random gaps
// and register settings, and lets the checker compare every objective beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
	import tsnlp_pkg::*;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	logic [1:0]         func = FN_PARAM;
	logic [5:0]         slot = '0;
	logic signed [31:0] value = '0;
	logic signed [31:0] sample_time = '0;
	logic               last = 1'b0;
	logic               done;
	logic [62:0]        objective;
	logic               saturated;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [4:0]         paddr = '0;
	logic [31:0]        pwdata = '0;
	logic [31:0]        prdata;
	logic               pready;
	int                 fail_count, pending, samples_seen, objectives_seen;
	int                 max_gap;
	int                 sent;

	always #5 clk = ~clk;

	trend_season_neg_log_posterior DUT (
		.clk, .arst_n, .start, .busy, .func, .slot, .value, .sample_time, .last,
		.done, .objective, .saturated, .psel, .penable, .pwrite, .paddr, .pwdata,
		.prdata, .pready
	);

	tsnlp_objective_checker checker_i (
		.clk, .arst_n, .start, .busy, .func, .slot, .value, .sample_time, .last,
		.done, .objective, .saturated, .psel, .penable, .pwrite, .pready, .paddr,
		.pwdata, .fail_count, .pending, .samples_seen, .objectives_seen
	);

	// Called at a rising edge; returns at the edge that accepts the beat with
	// start still high, so a back-to-back beat never lowers it.
	task automatic issue(logic [1:0] f, logic [5:0] s, logic [31:0] v, logic [31:0] t,
		logic l);
		int gap;
		gap = $urandom_range(0, max_gap);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		func <= f; slot <= s; value <= v; sample_time <= t; last <= l;
		do @(negedge clk); while (busy);
		@(posedge clk);
		sent++;
	endtask

	task automatic settle();
		start <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (600) @(posedge clk);
	endtask

	task automatic reg_write(reg_idx_t idx, logic [31:0] d);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= {idx, 2'b00}; pwdata <= d;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [31:0] pick_word();
		case ($urandom_range(0, 7))
			0: return $urandom();
			1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
			default: return 32'($signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000);
		endcase
	endfunction

	function automatic logic [31:0] pick_small();
		return 32'($signed($urandom_range(0, 32'h0000_4000)) - 32'sh0000_2000);
	endfunction

	task automatic load_all_sane();
		for (int i = 0; i < 47; i++)
			issue(FN_PARAM, 6'(i), pick_small(), $urandom(), $urandom_range(0, 1));
		for (int i = 0; i < 25; i++)
			issue(FN_CP, 6'(i), 32'(($signed(i) - 12) <<< 16), $urandom(), 1'b0);
	endtask

	task automatic set_regs(int mode);
		for (int r = 0; r < 6; r++) begin
			logic [31:0] d;
			case (mode)
				0: d = 32'h0;
				1: d = 32'hFFFF_FFFF;
				2: d = $urandom();
				default: d = $urandom_range(32'h100, 32'h4_0000);
			endcase
			reg_write(reg_idx_t'(r), d);
		end
	endtask

	initial begin
		#50_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		int n;
		max_gap = 6;
		sent = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Every store entry is written before the first sample reads it.
		load_all_sane();
		issue(FN_SAMPLE, 6'd63, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
		issue(FN_SAMPLE, 6'd0, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
		issue(FN_SAMPLE, 6'd0, 32'h0, 32'h0, 1'b0);
		issue(FN_SAMPLE, 6'd0, 32'h0001_0000, 32'hFFFF_0000, 1'b1);
		issue(2'd3, 6'd5, 32'h1234_5678, 32'h0, 1'b1);
		issue(FN_PARAM, 6'd63, 32'h7FFF_FFFF, 32'h0, 1'b1);
		issue(FN_CP, 6'd25, 32'h8000_0000, 32'h0, 1'b1);
		issue(FN_CP, 6'd63, 32'h8000_0000, 32'h0, 1'b0);
		issue(FN_PARAM, 6'd0, 32'h8000_0000, 32'h0, 1'b0);
		issue(FN_PARAM, 6'd46, 32'h7FFF_FFFF, 32'h0, 1'b0);
		issue(FN_PARAM, 6'd2, 32'h8000_0000, 32'h0, 1'b0);
		issue(FN_SAMPLE, 6'd0, 32'h0, 32'h0001_0000, 1'b1);
		load_all_sane();
		settle();

		for (int phase = 0; phase < 6; phase++) begin
			max_gap = (phase == 2) ? 0 : 6;
			if (phase > 0) begin
				settle();
				set_regs(phase % 4);
			end
			n = sent + 150;
			while (sent < n) begin
				// Occasional reloads and noise ahead of a well-formed series.
				repeat ($urandom_range(0, 3)) begin
					case ($urandom_range(0, 5))
						0: issue(2'd3, 6'($urandom()), $urandom(), $urandom(), 1'($urandom()));
						1: issue(FN_CP, 6'($urandom()), pick_word(), $urandom(), 1'($urandom()));
						2: issue(FN_PARAM, 6'($urandom()), pick_word(), $urandom(),
							1'($urandom()));
						default: issue(FN_PARAM, 6'($urandom_range(0, 46)), pick_small(),
							$urandom(), 1'($urandom()));
					endcase
				end
				if ($urandom_range(0, 9) == 0) begin
					settle();
					load_all_sane();
				end
				repeat ($urandom_range(0, 4))
					issue(FN_SAMPLE, 6'($urandom()), pick_word(), pick_word(), 1'b0);
				issue(FN_SAMPLE, 6'($urandom()), pick_word(), pick_word(), 1'b1);
			end
		end

		settle();
		if (fail_count == 0) begin
			$display("Covered %0d beats, %0d samples and %0d objectives over six settings.",
				sent, samples_seen, objectives_seen);
			$display("CHECK OK");
		end else begin
			$display("Covered %0d beats with %0d mismatches.", sent, fail_count);
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
